// ===== sv/tsca_pkg.sv =====
package tsca_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam logic [3:0]  LAST_INDEX  = 4'(FRAME_BYTES - 1);
  localparam logic [7:0]  CRC_POLY    = 8'h8C;
  localparam logic [15:0] SIGN_MARK   = 16'h0800;
  localparam logic [6:0]  HUNDRED     = 7'd100;

  // reflected crc-8, one data bit per step, lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (crc[0] ^ data[k]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  // sign, whole degrees in bits 14..8, hundredths in bits 6..0
  function automatic logic [15:0] pack_temp(input logic [15:0] x);
    logic [15:0] m;
    logic [10:0] hund;
    if ((x & SIGN_MARK) != 16'h0000) begin
      m = ~x + 16'd1 + SIGN_MARK;
    end else begin
      m = x;
    end
    hund = {7'd0, m[3:0]} * {4'd0, HUNDRED};
    return {m[11:4], 1'b0, hund[10:4]};
  endfunction

endpackage

// ===== sv/temp_scratchpad_check_average_core.sv =====
// a result is valid once the ninth byte of a frame is accepted and has passed stages s1, s2 and s3
// throughput: one byte per cycle; the ninth byte of a frame is held off only while
//   the previous frame's result is still in the three-stage average pipeline or unclaimed
// reset: rst_ni clears byte count, crc, sample window, running sum and last result
//   to zero; no clearing pass, the block takes bytes in the first cycle after reset
module temp_scratchpad_check_average_core
  import tsca_pkg::*;
#(
  parameter int unsigned AVG_WINDOW = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         scratch_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic [15:0]        temp_word_o,
  output logic signed [15:0] averaged_raw_o
);

  // history holds the previous window-1 accepted readings, oldest at index 0
  localparam int unsigned HIST_DEPTH = AVG_WINDOW - 1;
  // signed sum of a full window
  localparam int unsigned SUM_W = 16 + $clog2(AVG_WINDOW);
  // the sum plus an offset of AVG_WINDOW * 2^(SUM_W-1) is never negative and fits here
  localparam int unsigned U_W = SUM_W + $clog2(AVG_WINDOW + 1);
  localparam logic [U_W-1:0] OFFSET = U_W'(64'(AVG_WINDOW) << (SUM_W - 1));
  // floor(2^U_W / window): the quotient estimate is exact or one low
  localparam logic [U_W-1:0] RECIP = U_W'((64'd1 << U_W) / AVG_WINDOW);
  localparam logic [U_W-1:0] WIN_U = U_W'(AVG_WINDOW);

  // frame state
  logic [3:0]  byte_index_q, byte_index_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  raw_low_q, raw_high_q;
  logic [15:0] hist_q [HIST_DEPTH];
  logic signed [SUM_W-1:0] hist_sum_q, hist_sum_d;
  logic [15:0] last_temp_q, last_avg_q;

  // average pipeline
  logic                    s1_valid_q, s1_ok_q;
  logic signed [SUM_W-1:0] total_q;
  logic                    s2_valid_q, s2_ok_q;
  logic [U_W-1:0]          u_q;
  logic [2*U_W-1:0]        prod_q;
  logic                    s3_valid_q, s3_ok_q;
  logic [15:0]             avg_q;

  // result register
  logic        out_valid_q;
  logic        out_status_q;
  logic [15:0] out_temp_q, out_avg_q;

  logic                    in_accept, out_accept, frame_end, frame_ok, busy;
  logic [15:0]             sample;
  logic signed [SUM_W-1:0] sample_ext, oldest_ext, total_d;
  logic [U_W-1:0]          u_d, q0, rem;
  logic [U_W-1:0]          q_fix;

  // only one frame result is in flight at a time; bytes 0..7 are never held off
  assign busy       = s1_valid_q | s2_valid_q | s3_valid_q | out_valid_q;
  assign in_stall_o = (byte_index_q == LAST_INDEX) && busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign frame_end  = in_accept && (byte_index_q == LAST_INDEX);

  assign crc_d    = crc8_byte(crc_q, scratch_byte_i);
  assign frame_ok = (crc_d == 8'h00);

  // reading from bytes 0 and 1, sign-extended into the sum width
  assign sample     = {raw_high_q, raw_low_q};
  assign sample_ext = {{(SUM_W - 16){sample[15]}}, sample};
  assign oldest_ext = {{(SUM_W - 16){hist_q[0][15]}}, hist_q[0]};
  assign total_d    = hist_sum_q + sample_ext;
  // running sum drops the oldest reading and takes the new one
  assign hist_sum_d = total_d - oldest_ext;

  assign byte_index_d = (byte_index_q == LAST_INDEX) ? 4'd0 : byte_index_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= 4'd0;
      crc_q        <= 8'h00;
      raw_low_q    <= 8'h00;
      raw_high_q   <= 8'h00;
      hist_sum_q   <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= 16'h0000;
      end
    end else if (in_accept) begin
      byte_index_q <= byte_index_d;
      if (byte_index_q == 4'd0) begin
        raw_low_q <= scratch_byte_i;
      end
      if (byte_index_q == 4'd1) begin
        raw_high_q <= scratch_byte_i;
      end
      if (frame_end) begin
        crc_q <= 8'h00;
        // a bad frame leaves the window alone
        if (frame_ok) begin
          hist_sum_q <= hist_sum_d;
          for (int i = 0; i + 1 < HIST_DEPTH; i++) begin
            hist_q[i] <= hist_q[i + 1];
          end
          hist_q[HIST_DEPTH - 1] <= sample;
        end
      end else begin
        crc_q <= crc_d;
      end
    end
  end

  // stage 2: offset the sum so that floor division becomes unsigned, then multiply
  // by the reciprocal of the window
  assign u_d = {{(U_W - SUM_W){total_q[SUM_W-1]}}, total_q} + OFFSET;

  // stage 3: the estimate may be one low, one compare fixes it
  assign q0    = prod_q[2*U_W-1:U_W];
  assign rem   = u_q - U_W'(q0 * WIN_U);
  assign q_fix = (rem >= WIN_U) ? q0 + U_W'(1) : q0;
  // the offset removed from the quotient is 2^(SUM_W-1), a multiple of 2^16,
  // so the low 16 bits are already the average

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_temp_q <= 16'h0000;
      last_avg_q  <= 16'h0000;
    end else begin
      s1_valid_q <= frame_end;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (s3_valid_q) begin
        out_valid_q <= 1'b1;
        if (s3_ok_q) begin
          last_avg_q  <= avg_q;
          last_temp_q <= pack_temp(avg_q);
        end
      end else if (out_accept) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pipeline payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      s1_ok_q <= frame_ok;
      total_q <= total_d;
    end
    if (s1_valid_q) begin
      s2_ok_q <= s1_ok_q;
      u_q     <= u_d;
      prod_q  <= {{U_W{1'b0}}, u_d} * {{U_W{1'b0}}, RECIP};
    end
    if (s2_valid_q) begin
      s3_ok_q <= s2_ok_q;
      avg_q   <= q_fix[15:0];
    end
    if (s3_valid_q) begin
      out_status_q <= !s3_ok_q;
      if (s3_ok_q) begin
        out_avg_q  <= avg_q;
        out_temp_q <= pack_temp(avg_q);
      end else begin
        // crc error repeats the last good result
        out_avg_q  <= last_avg_q;
        out_temp_q <= last_temp_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign temp_word_o    = out_temp_q;
  assign averaged_raw_o = $signed(out_avg_q);

  // at most one frame result in flight
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q}))
    else $error("more than one frame result in flight");

  // the last byte of a frame starts the average pipeline
  a_frame_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> s1_valid_q && byte_index_q == 4'd0)
    else $error("frame end did not start the pipeline");

  // a shown result always matches the held last result
  a_out_matches_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_temp_q == last_temp_q) && (out_avg_q == last_avg_q))
    else $error("result differs from last result");

  // only the ninth byte is ever held off
  a_stall_last_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> byte_index_q == LAST_INDEX)
    else $error("stall on a byte other than the last");

  // a waiting result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_temp_q) && $stable(out_status_q))
    else $error("stalled result changed");

endmodule
